[design/psjg_pkg.sv]
package psjg_pkg;

    // Default geometry
    localparam int POS_WIDTH_DEF        = 32;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    // Axes per position sample
    localparam int NUM_AXES = 3;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int LIMIT_W    = 31;
    localparam int CFG_DATA_W = 31;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FILTER_ENABLE    = 2'd0,
        REG_SMOOTHING_WEIGHT = 2'd1,
        REG_JUMP_LIMIT       = 2'd2
    } cfg_reg_t;

    // Register reset values
    localparam logic                WEIGHT_ENABLE_RST = 1'b0;
    localparam int unsigned         WEIGHT_RST        = 6554;
    localparam logic [LIMIT_W-1:0]  JUMP_LIMIT_RST    = 31'd9830;

endpackage

[design/pose_smoother_with_jump_gate.sv]
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  raw_x, raw_y, raw_z
// m_axis    out  m_axis_tvalid/m_axis_tready  out_x, out_y, out_z
// cfg       in   cfg_wr_en                    cfg_addr, cfg_wr_data
//
// One transaction per cycle sustained while m_axis_tready stays high; each
// result passes two registers: the accepting edge loads the input register,
// and a later advance loads the result register.
// The per-cycle loop runs from the stored position through the subtract,
// squaring, threshold compare and blend back to the stored position.
// Reset (aresetn low, synchronous) empties both registers, clears primed
// and loads the register reset values; the stored position clears to zero.
// A stalled result holds in the result register while the input register
// still takes one more transaction.
module pose_smoother_with_jump_gate #(
    parameter int POS_WIDTH        = psjg_pkg::POS_WIDTH_DEF,
    parameter int WEIGHT_FRAC_BITS = psjg_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    // raw_x, raw_y, raw_z from bit 0 up, zero padding above
    input  logic [((psjg_pkg::NUM_AXES*POS_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // out_x, out_y, out_z from bit 0 up, zero padding above
    output logic [((psjg_pkg::NUM_AXES*POS_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    input  logic                                          cfg_wr_en,
    input  logic [psjg_pkg::CFG_ADDR_W-1:0]               cfg_addr,
    input  logic [psjg_pkg::CFG_DATA_W-1:0]               cfg_wr_data
);
    import psjg_pkg::*;

    localparam int P       = POS_WIDTH;
    localparam int F       = WEIGHT_FRAC_BITS;
    localparam int D       = P + 1;
    localparam int CMP_W   = (D > LIMIT_W) ? D : LIMIT_W;
    localparam int PROD_W  = F + 2 + D;
    localparam int SQ_W    = 2 * LIMIT_W;
    localparam int SUM_W   = SQ_W + 2;

    // Configuration registers
    logic                 filter_enable_reg;
    logic [F:0]           smoothing_weight_reg;
    logic [LIMIT_W-1:0]   jump_limit_reg;

    // Input register
    logic                 in_valid_reg;
    logic signed [P-1:0]  in_raw_reg [NUM_AXES];

    // Filter state
    logic                 primed_reg;
    logic                 primed_next;
    logic signed [P-1:0]  smoothed_reg  [NUM_AXES];
    logic signed [P-1:0]  smoothed_next [NUM_AXES];

    // Result register
    logic                 out_valid_reg;
    logic signed [P-1:0]  out_data_reg  [NUM_AXES];
    logic signed [P-1:0]  out_data_next [NUM_AXES];

    logic                 advance;
    logic                 s_accept;

    // Datapath signals
    logic signed [D-1:0]      diff     [NUM_AXES];
    logic [D-1:0]             mag      [NUM_AXES];
    logic [CMP_W-1:0]         mag_cmp  [NUM_AXES];
    logic [LIMIT_W-1:0]       mag_sq_in[NUM_AXES];
    logic [SQ_W-1:0]          mag_sq   [NUM_AXES];
    logic [NUM_AXES-1:0]      far;
    logic [SUM_W-1:0]         dist_sq;
    logic [SQ_W-1:0]          limit_sq;
    logic                     snap;
    logic [F:0]               w_eff;
    logic signed [F+1:0]      w_s;
    logic signed [PROD_W-1:0] prod     [NUM_AXES];
    logic signed [D-1:0]      step     [NUM_AXES];
    logic signed [D-1:0]      blended  [NUM_AXES];

    // Handshake: the result register frees up when empty or being taken
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_enable_reg    <= WEIGHT_ENABLE_RST;
            smoothing_weight_reg <= (F + 1)'(WEIGHT_RST);
            jump_limit_reg       <= JUMP_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FILTER_ENABLE:    filter_enable_reg    <= cfg_wr_data[0];
                REG_SMOOTHING_WEIGHT: smoothing_weight_reg <= cfg_wr_data[F:0];
                REG_JUMP_LIMIT:       jump_limit_reg       <= cfg_wr_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture input transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                in_raw_reg[i] <= s_axis_tdata[i*P +: P];
            end
        end
    end

    // Weight saturates at one
    always_comb begin
        w_eff = smoothing_weight_reg[F] ? (F + 1)'(1) << F : smoothing_weight_reg;
        w_s   = signed'({1'b0, w_eff});
    end

    // Per-axis distance and blend
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            diff[i]      = D'(in_raw_reg[i]) - D'(smoothed_reg[i]);
            mag[i]       = diff[i][D-1] ? D'(-diff[i]) : D'(diff[i]);
            mag_cmp[i]   = CMP_W'(mag[i]);
            far[i]       = mag_cmp[i] > CMP_W'(jump_limit_reg);
            mag_sq_in[i] = LIMIT_W'(mag_cmp[i]);
            mag_sq[i]    = SQ_W'(mag_sq_in[i]) * SQ_W'(mag_sq_in[i]);
            prod[i]      = PROD_W'(w_s) * PROD_W'(diff[i]);
            step[i]      = D'(prod[i] >>> F);
            blended[i]   = D'(smoothed_reg[i]) + step[i];
        end
    end

    // Jump gate: per-axis test first, then squared distance
    always_comb begin
        limit_sq = SQ_W'(jump_limit_reg) * SQ_W'(jump_limit_reg);
        dist_sq  = SUM_W'(mag_sq[0]) + SUM_W'(mag_sq[1]) + SUM_W'(mag_sq[2]);
        snap     = (jump_limit_reg != '0) &&
                   ((|far) || (dist_sq > SUM_W'(limit_sq)));
    end

    // Next state and result
    always_comb begin
        primed_next = primed_reg;
        for (int i = 0; i < NUM_AXES; i++) begin
            smoothed_next[i] = smoothed_reg[i];
            out_data_next[i] = in_raw_reg[i];
        end
        if (!filter_enable_reg) begin
            primed_next = 1'b0;
        end else if (!primed_reg || snap) begin
            primed_next = 1'b1;
            for (int i = 0; i < NUM_AXES; i++) begin
                smoothed_next[i] = in_raw_reg[i];
            end
        end else begin
            for (int i = 0; i < NUM_AXES; i++) begin
                smoothed_next[i] = P'(blended[i]);
                out_data_next[i] = P'(blended[i]);
            end
        end
    end

    // Advance state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                smoothed_reg[i] <= '0;
            end
        end else if (advance) begin
            primed_reg   <= primed_next;
            smoothed_reg <= smoothed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // Pack result
    always_comb begin
        m_axis_tdata = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            m_axis_tdata[i*P +: P] = out_data_reg[i];
        end
    end

    // A disabled pass clears primed and forwards the raw sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !filter_enable_reg |=> !primed_reg &&
            m_axis_tdata[P-1:0] == $past(in_raw_reg[0]))
        else $error("disabled pass did not forward raw sample");

    // First enabled sample primes the state with the raw value
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && filter_enable_reg && !primed_reg |=> primed_reg &&
            smoothed_reg[0] == $past(in_raw_reg[0]) &&
            smoothed_reg[2] == $past(in_raw_reg[2]))
        else $error("priming did not load raw sample");

    // When enabled, the result always equals the new stored position
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && filter_enable_reg |=>
            m_axis_tdata[2*P-1:P] == smoothed_reg[1])
        else $error("result differs from stored position");

    // A held result blocks no more than one buffered input
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken with both registers full");

    // Stored position changes only on an advance
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(advance) && $past(aresetn) |-> $stable(smoothed_reg[0]))
        else $error("state changed without an advance");

endmodule

[tb/pose_smoother_checker.sv]
module pose_smoother_checker #(
    parameter int PW     = psjg_pkg::POS_WIDTH_DEF,
    parameter int FRAC   = psjg_pkg::WEIGHT_FRAC_BITS_DEF,
    parameter int DATA_W = ((psjg_pkg::NUM_AXES*PW+7)/8)*8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // raw_x, raw_y, raw_z from bit 0 up
    input  logic [DATA_W-1:0]                 s_axis_tdata,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    // out_x, out_y, out_z from bit 0 up
    input  logic [DATA_W-1:0]                 m_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_wr_en,
    input  logic [psjg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [psjg_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output int unsigned                       mismatches,
    output int unsigned                       pending
);
    import psjg_pkg::*;

    localparam longint WEIGHT_ONE = longint'(1) << FRAC;
    localparam int     SQ_W       = 2*PW + 4;

    // Mirror of the block's registers and filter state
    logic                 filt_en;
    logic [FRAC:0]        weight_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic signed [PW-1:0] held [NUM_AXES];
    logic                 primed;

    // Expected results waiting for their result transaction
    logic [DATA_W-1:0]    expected_poses [$];
    logic [DATA_W-1:0]    want;
    string                axis_name [NUM_AXES] = '{"x", "y", "z"};

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t: %s", $time, msg);
    endtask

    // old + floor(w * (raw - old) / 2^FRAC), done in 64-bit signed arithmetic
    function automatic logic signed [PW-1:0] blend_axis(
        input logic signed [PW-1:0] raw,
        input logic signed [PW-1:0] old,
        input longint               w
    );
        longint diff;
        diff = longint'(raw) - longint'(old);
        return PW'(longint'(old) + ((diff * w) >>> FRAC));
    endfunction

    // Advance the filter state by one raw position and queue the output
    function automatic void smooth_pose(input logic [DATA_W-1:0] tdata);
        logic signed [PW-1:0] raw [NUM_AXES];
        logic [DATA_W-1:0]    result;
        logic [SQ_W-1:0]      mag;
        logic [SQ_W-1:0]      dist_sq;
        logic [SQ_W-1:0]      lim_sq;
        longint               diff;
        longint               w;
        bit                   snap;
        result = '0;
        for (int a = 0; a < NUM_AXES; a++)
            raw[a] = tdata[a*PW +: PW];
        if (!filt_en) begin
            // pass raw through; stored position is left alone
            primed = 1'b0;
            for (int a = 0; a < NUM_AXES; a++)
                result[a*PW +: PW] = raw[a];
        end else begin
            if (!primed) begin
                for (int a = 0; a < NUM_AXES; a++)
                    held[a] = raw[a];
                primed = 1'b1;
            end else begin
                // full-width squared distance, strictly greater snaps
                dist_sq = '0;
                for (int a = 0; a < NUM_AXES; a++) begin
                    diff = longint'(raw[a]) - longint'(held[a]);
                    mag = SQ_W'((diff < 0) ? -diff : diff);
                    dist_sq = dist_sq + mag * mag;
                end
                lim_sq = SQ_W'(limit_reg);
                lim_sq = lim_sq * lim_sq;
                snap = (limit_reg != '0) && (dist_sq > lim_sq);
                w = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : longint'(weight_reg);
                for (int a = 0; a < NUM_AXES; a++)
                    held[a] = snap ? raw[a] : blend_axis(raw[a], held[a], w);
            end
            for (int a = 0; a < NUM_AXES; a++)
                result[a*PW +: PW] = held[a];
        end
        expected_poses.push_back(result);
    endfunction

    // Track register writes, predict on input transactions, compare outputs
    always @(posedge aclk) begin
        if (!aresetn) begin
            filt_en    = WEIGHT_ENABLE_RST;
            weight_reg = (FRAC + 1)'(WEIGHT_RST);
            limit_reg  = JUMP_LIMIT_RST;
            primed     = 1'b0;
            for (int a = 0; a < NUM_AXES; a++)
                held[a] = '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_FILTER_ENABLE:    filt_en    = cfg_wr_data[0];
                    REG_SMOOTHING_WEIGHT: weight_reg = cfg_wr_data[FRAC:0];
                    REG_JUMP_LIMIT:       limit_reg  = cfg_wr_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                smooth_pose(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_poses.size() == 0) begin
                    report_mismatch($sformatf("result %h with no input pending",
                                              m_axis_tdata));
                end else begin
                    want = expected_poses.pop_front();
                    for (int a = 0; a < NUM_AXES; a++) begin
                        if (m_axis_tdata[a*PW +: PW] !== want[a*PW +: PW])
                            report_mismatch($sformatf("out_%s got %h want %h",
                                axis_name[a], m_axis_tdata[a*PW +: PW],
                                want[a*PW +: PW]));
                    end
                    if ((m_axis_tdata >> (NUM_AXES*PW)) !== '0)
                        report_mismatch($sformatf("padding got %h",
                                                  m_axis_tdata >> (NUM_AXES*PW)));
                end
            end
        end
        pending = expected_poses.size();
    end

endmodule

[tb/tb.sv]
module tb;
    import psjg_pkg::*;

    localparam int PW              = POS_WIDTH_DEF;
    localparam int WFB             = WEIGHT_FRAC_BITS_DEF;
    localparam int DATA_W          = ((NUM_AXES*PW+7)/8)*8;
    localparam int LIMIT_CYCLES    = 300000;
    localparam int HOLD_CYCLES     = 64;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 123;
    localparam int DRAIN_CYCLES    = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;
    localparam logic [WFB:0]          WEIGHT_FULL  = (WFB + 1)'(1) << WFB;
    localparam logic [WFB:0]          WEIGHT_HALF  = (WFB + 1)'(1) << (WFB - 1);
    localparam logic [LIMIT_W-1:0]    LIMIT_MAX    = '1;

    localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [PW-1:0] ONE_M   = 1 << 16;
    localparam logic signed [PW-1:0] GATE_M  = 5 * ONE_M;
    localparam logic signed [PW-1:0] GX      = ONE_M;
    localparam logic signed [PW-1:0] GY      = 2 * ONE_M;
    localparam logic signed [PW-1:0] GZ      = -3 * ONE_M;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic [DATA_W-1:0]     s_axis_tdata  = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data   = '0;

    int unsigned           mismatches;
    int unsigned           pending;
    int unsigned           cycle_count   = 0;
    bit                    idle_on       = 1'b1;
    bit                    hold_request  = 1'b0;
    logic signed [PW-1:0]  walk [NUM_AXES] = '{default: '0};

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pose_smoother_with_jump_gate u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    pose_smoother_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("pose_smoother_with_jump_gate: mismatch");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            stall = idle_on ? $urandom_range(0, 10) : 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Offer one position and hold it until the transaction completes
    task automatic send_pose(input logic [PW-1:0] x, input logic [PW-1:0] y,
                             input logic [PW-1:0] z);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata  <= DATA_W'({z, y, x});
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    // Program all three registers, with junk above the enable and weight fields
    task automatic set_filter(input logic en, input logic [WFB:0] weight,
                              input logic [LIMIT_W-1:0] lim);
        logic [CFG_DATA_W-1:0] junk;
        wait_for_results();
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_FILTER_ENABLE, {junk[CFG_DATA_W-1:1], en});
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_SMOOTHING_WEIGHT, {junk[CFG_DATA_W-1:WFB+1], weight});
        write_reg(REG_JUMP_LIMIT, CFG_DATA_W'(lim));
    endtask

    // Mostly a random walk scaled to the jump limit, sometimes wild or extreme
    task automatic send_random_pose(input logic [LIMIT_W-1:0] lim);
        logic signed [PW-1:0] p [NUM_AXES];
        longint               base;
        longint               span;
        longint               delta;
        int                   kind;
        kind = $urandom_range(0, 9);
        base = (lim != 0) ? longint'(lim) : ((kind == 2) ? (longint'(1) << 24) : 65536);
        span = ($urandom_range(0, 3) == 0) ? base + base / 4 + 1 : base / 2 + 1;
        if (span > (longint'(1) << 30))
            span = longint'(1) << 30;
        for (int a = 0; a < NUM_AXES; a++) begin
            case (kind)
                0: p[a] = PW'($urandom);
                1: begin
                    case ($urandom_range(0, 3))
                        0:       p[a] = POS_MAX;
                        1:       p[a] = POS_MIN;
                        2:       p[a] = '0;
                        default: p[a] = '1;
                    endcase
                end
                default: begin
                    delta = longint'($urandom_range(0, 32'(2 * span))) - span;
                    p[a]  = walk[a] + PW'(delta);
                end
            endcase
            walk[a] = p[a];
        end
        send_pose(p[0], p[1], p[2]);
    endtask

    initial begin
        logic               en;
        logic [WFB:0]       w;
        logic [LIMIT_W-1:0] lim;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Filter off after reset: raw passes through
        send_pose('0, '0, '0);
        send_pose(POS_MAX, POS_MIN, '1);
        send_pose(POS_MIN, POS_MAX, 1);
        send_pose(32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_F0F0);

        // All-ones writes enable and saturate the weight to one, a zero limit turns the gate off;
        // a write to the unmapped index must change nothing
        wait_for_results();
        write_reg(REG_FILTER_ENABLE, '1);
        write_reg(REG_SMOOTHING_WEIGHT, '1);
        write_reg(REG_JUMP_LIMIT, '0);
        write_reg(REG_UNMAPPED, '1);
        send_pose(POS_MAX, POS_MAX, POS_MAX);
        send_pose(POS_MIN, POS_MIN, POS_MIN);
        send_pose(POS_MAX, POS_MIN, '0);

        // Zero weight holds the stored position
        set_filter(1'b1, '0, '0);
        send_pose('0, '0, '0);
        send_pose(POS_MIN, POS_MAX, POS_MIN);

        // Half weight across the full range, negative steps floor
        set_filter(1'b1, WEIGHT_HALF, '0);
        send_pose(POS_MAX, POS_MIN, '1);
        send_pose(POS_MIN, POS_MAX, 1);
        send_pose(3, -3, 0);

        // Disable, then re-enable so the gate tests start from a fresh prime
        set_filter(1'b0, '0, LIMIT_W'(GATE_M));
        send_pose(POS_MAX, POS_MIN, POS_MAX);
        set_filter(1'b1, '0, LIMIT_W'(GATE_M));
        send_pose(GX, GY, GZ);
        send_pose(GX + 3 * ONE_M, GY + 4 * ONE_M, GZ);
        send_pose(GX + 3 * ONE_M, GY + 4 * ONE_M, GZ + 1);
        send_pose(GX + 8 * ONE_M + 1, GY + 4 * ONE_M, GZ + 1);
        send_pose(GX + 3 * ONE_M + 1, GY + 4 * ONE_M, GZ + 1);
        send_pose(GX + 8 * ONE_M + 1, GY + 4 * ONE_M, GZ - GATE_M);

        // Disabled keeps the stored position but drops priming
        set_filter(1'b0, WEIGHT_HALF, LIMIT_W'(GATE_M));
        send_pose(POS_MIN, '0, POS_MAX);
        set_filter(1'b1, WEIGHT_HALF, LIMIT_W'(GATE_M));
        send_pose(-ONE_M, ONE_M, 7);

        // Random phases, each with its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    en = 1'b1; w = WEIGHT_FULL; lim = LIMIT_MAX;
                end
                1: begin
                    en = 1'b1; w = '0; lim = 1;
                end
                2: begin
                    en = 1'b0; w = (WFB + 1)'($urandom); lim = LIMIT_W'($urandom);
                end
                default: begin
                    en = ($urandom_range(0, 4) != 0);
                    case ($urandom_range(0, 6))
                        0:       w = '0;
                        1:       w = 1;
                        2:       w = WEIGHT_FULL - 1;
                        3:       w = WEIGHT_FULL;
                        4:       w = (WFB + 1)'($urandom_range(WEIGHT_FULL + 1,
                                                              (1 << (WFB + 1)) - 1));
                        default: w = (WFB + 1)'($urandom_range(0, WEIGHT_FULL));
                    endcase
                    case ($urandom_range(0, 5))
                        0:       lim = '0;
                        1:       lim = 1;
                        2:       lim = LIMIT_MAX;
                        3:       lim = LIMIT_W'($urandom_range(1, 1 << 16));
                        4:       lim = LIMIT_W'($urandom_range(1 << 16, 1 << 24));
                        default: lim = LIMIT_W'($urandom);
                    endcase
                end
            endcase
            set_filter(en, w, lim);
            idle_on = (ph % 3 != 1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // fill the block while the result side holds off
                if (ph == 4 && i == 10)
                    hold_request = 1'b1;
                send_random_pose(lim);
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("pose_smoother_with_jump_gate: match");
        else
            $display("pose_smoother_with_jump_gate: mismatch");
        $finish;
    end

endmodule
